FILE: hdl/btmx_pkg.sv
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared types and constants for the binary trie maximum-XOR block: payload
// structs, request and status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int unsigned KEY_BITS_DEF      = 32;
  localparam int unsigned NODE_CAPACITY_DEF = 8192;

  // Fixed payload widths.
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned RES_W  = 32;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_DONE
  } fsm_state_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key_value;
  } req_word_t;

  typedef struct packed {
    logic [RES_W-1:0]  xor_result;
    logic [RES_W-1:0]  best_so_far;
    logic [STAT_W-1:0] status;
  } res_word_t;

endpackage

`default_nettype wire

FILE: hdl/btmx_node_mem.sv
// ----------------------------------------------------------------------------
// btmx_node_mem
// Node pool: one entry per trie node holding its two child links. One write
// port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_node_mem #(
  parameter int unsigned DEPTH  = 8192,
  parameter int unsigned ADDR_W = 13,
  parameter int unsigned DATA_W = 26
) (
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: hdl/btmx_ctrl.sv
// ----------------------------------------------------------------------------
// btmx_ctrl
// Trie walker: steps one key bit per cycle through the node pool, allocates
// missing nodes for inserts, and keeps root links, pool fill and running best.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_ctrl #(
  parameter int unsigned KEY_BITS      = 32,
  parameter int unsigned NODE_CAPACITY = 8192,
  parameter int unsigned PTR_W         = 13
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire btmx_pkg::req_word_t  in_data_i,
  input  wire logic                 out_free_i,
  output logic                      res_valid_o,
  output btmx_pkg::res_word_t       res_data_o,
  output logic                      mem_rd_en_o,
  output logic [PTR_W-1:0]          mem_rd_addr_o,
  input  wire logic [2*PTR_W-1:0]   mem_rd_data_i,
  output logic                      mem_wr_en_o,
  output logic [PTR_W-1:0]          mem_wr_addr_o,
  output logic [2*PTR_W-1:0]        mem_wr_data_o
);

  import btmx_pkg::*;

  localparam int unsigned LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned CNT_W = $clog2(NODE_CAPACITY + 1);
  localparam int unsigned SUM_W = CNT_W + LVL_W + 1;

  fsm_state_e          state_q, state_d;
  req_e                req_q, req_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [KEY_BITS-1:0] acc_q, acc_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic                cur_root_q, cur_root_d;
  logic [PTR_W-1:0]    cur_node_q, cur_node_d;
  logic [PTR_W-1:0]    alloc_q, alloc_d;
  logic                leaf_q, leaf_d;
  stat_e               stat_q, stat_d;
  logic [PTR_W-1:0]    root0_q, root0_d;
  logic [PTR_W-1:0]    root1_q, root1_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic                has_keys_q, has_keys_d;
  logic [RES_W-1:0]    best_q, best_d;

  logic [PTR_W-1:0]    child0, child1, opp, same, nxt, nu_ptr, alloc_p1;
  logic                bit_v;
  logic [KEY_BITS-1:0] acc_hit;
  logic [RES_W-1:0]    acc_now;
  logic [SUM_W-1:0]    need_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      root0_q    <= '0;
      root1_q    <= '0;
      used_q     <= CNT_W'(1);
      has_keys_q <= 1'b0;
      best_q     <= '0;
    end else begin
      state_q    <= state_d;
      root0_q    <= root0_d;
      root1_q    <= root1_d;
      used_q     <= used_d;
      has_keys_q <= has_keys_d;
      best_q     <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    acc_q      <= acc_d;
    lvl_q      <= lvl_d;
    cur_root_q <= cur_root_d;
    cur_node_q <= cur_node_d;
    alloc_q    <= alloc_d;
    leaf_q     <= leaf_d;
    stat_q     <= stat_d;
  end

  // Current node links come from the root registers or last cycle's read.
  assign child0   = cur_root_q ? root0_q : mem_rd_data_i[PTR_W-1:0];
  assign child1   = cur_root_q ? root1_q : mem_rd_data_i[2*PTR_W-1:PTR_W];
  assign bit_v    = key_q[lvl_q];
  assign opp      = bit_v ? child0 : child1;
  assign same     = bit_v ? child1 : child0;
  assign nxt      = same;
  assign nu_ptr   = PTR_W'(used_q);
  assign alloc_p1 = alloc_q + PTR_W'(1);
  assign need_sum = SUM_W'(used_q) + SUM_W'(lvl_q) + SUM_W'(1);

  always_comb begin
    acc_hit        = acc_q;
    acc_hit[lvl_q] = 1'b1;
  end
  assign acc_now = (opp != '0) ? RES_W'(acc_hit) : RES_W'(acc_q);

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    key_d         = key_q;
    acc_d         = acc_q;
    lvl_d         = lvl_q;
    cur_root_d    = cur_root_q;
    cur_node_d    = cur_node_q;
    alloc_d       = alloc_q;
    leaf_d        = leaf_q;
    stat_d        = stat_q;
    root0_d       = root0_q;
    root1_d       = root1_q;
    used_d        = used_q;
    has_keys_d    = has_keys_q;
    best_d        = best_q;
    in_stall_o    = 1'b1;
    res_valid_o   = 1'b0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = nxt;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = cur_node_q;
    mem_wr_data_o = '0;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d      = req_e'(in_data_i.req_type);
          key_d      = KEY_BITS'(in_data_i.key_value);
          acc_d      = '0;
          lvl_d      = LVL_W'(KEY_BITS - 1);
          cur_root_d = 1'b1;
          cur_node_d = '0;
          stat_d     = STAT_OK;
          state_d    = ST_DONE;
          case (req_e'(in_data_i.req_type))
            REQ_INSERT: state_d = ST_WALK;
            REQ_QUERY: begin
              if (has_keys_q) begin
                state_d = ST_WALK;
              end else begin
                stat_d = STAT_EMPTY;
              end
            end
            REQ_CLEAR: begin
              root0_d    = '0;
              root1_d    = '0;
              used_d     = CNT_W'(1);
              has_keys_d = 1'b0;
              best_d     = '0;
            end
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        if (req_q == REQ_QUERY) begin
          acc_d = KEY_BITS'(acc_now);
          if (opp != '0) begin
            acc_d         = acc_hit;
            mem_rd_addr_o = opp;
          end
          if ((opp == '0 && same == '0) || lvl_q == '0) begin
            // Walk finished or hit a dead end: fold into the running best.
            if (acc_now > best_q) begin
              best_d = acc_now;
            end
            state_d = ST_DONE;
          end else begin
            mem_rd_en_o = 1'b1;
            lvl_d       = lvl_q - LVL_W'(1);
            cur_root_d  = 1'b0;
            cur_node_d  = mem_rd_addr_o;
          end
        end else begin
          if (nxt == '0) begin
            if (need_sum > SUM_W'(NODE_CAPACITY)) begin
              stat_d  = STAT_FULL;
              state_d = ST_DONE;
            end else begin
              // Hook the first new node under the current node.
              if (cur_root_q) begin
                if (bit_v) begin
                  root1_d = nu_ptr;
                end else begin
                  root0_d = nu_ptr;
                end
              end else begin
                mem_wr_en_o   = 1'b1;
                mem_wr_addr_o = cur_node_q;
                mem_wr_data_o = bit_v ? {nu_ptr, child0} : {child1, nu_ptr};
              end
              alloc_d = nu_ptr;
              leaf_d  = (lvl_q == '0);
              if (lvl_q != '0) begin
                lvl_d = lvl_q - LVL_W'(1);
              end
              state_d = ST_ALLOC;
            end
          end else if (lvl_q == '0) begin
            // Duplicate key: nothing to allocate.
            has_keys_d = 1'b1;
            state_d    = ST_DONE;
          end else begin
            mem_rd_en_o = 1'b1;
            lvl_d       = lvl_q - LVL_W'(1);
            cur_root_d  = 1'b0;
            cur_node_d  = nxt;
          end
        end
      end

      ST_ALLOC: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = alloc_q;
        if (leaf_q) begin
          mem_wr_data_o = '0;
          used_d        = CNT_W'(alloc_q) + CNT_W'(1);
          has_keys_d    = 1'b1;
          state_d       = ST_DONE;
        end else begin
          mem_wr_data_o = key_q[lvl_q] ? {alloc_p1, {PTR_W{1'b0}}}
                                       : {{PTR_W{1'b0}}, alloc_p1};
          alloc_d       = alloc_p1;
          if (lvl_q == '0) begin
            leaf_d = 1'b1;
          end else begin
            lvl_d = lvl_q - LVL_W'(1);
          end
        end
      end

      ST_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign res_data_o.xor_result  = RES_W'(acc_q);
  assign res_data_o.best_so_far = best_q;
  assign res_data_o.status      = stat_q;

  // The pool is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_rd_en_o && mem_wr_en_o))
    else $error("node pool read and write in the same cycle");

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q >= CNT_W'(1)) && (used_q <= CNT_W'(NODE_CAPACITY)))
    else $error("node count out of range");

  a_result_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_free_i)
    else $error("result issued while output register is busy");

  a_walk_descends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && $past(state_q) == ST_WALK)
      |-> (lvl_q == LVL_W'($past(lvl_q) - LVL_W'(1))))
    else $error("walk did not advance one level");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_data_i.req_type == REQ_CLEAR)
      |=> (used_q == CNT_W'(1) && !has_keys_q && best_q == '0))
    else $error("clear left trie state behind");

endmodule

`default_nettype wire

FILE: hdl/binary_trie_max_xor.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Binary trie of unsigned keys with insert, maximum-XOR query and clear.
//
// Usage: words enter on in_valid_i / in_stall_o and leave on out_valid_o /
// out_stall_i; a word moves when valid is high and stall is low. Each input
// word yields exactly one result word, in order.
// The trie is walked one key bit per cycle, with at most one read of the
// node pool per level. An insert that allocates new nodes swaps the reads
// below its first missing link for one pool write per new node. Clear and
// empty-trie queries skip the walk. A new word is accepted in the cycle
// after the previous result moved into the output register, so one item is
// in flight while a finished result may still wait there.
// Reset empties the trie (root links in flip-flops), sets the node count to
// one and zeroes the running best; no sweep of the pool is needed, since a
// node is written when it is allocated. When the receiver stalls, the result
// holds and the next item stops in its finishing step until room frees.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_max_xor #(
  parameter int unsigned KEY_BITS      = btmx_pkg::KEY_BITS_DEF,
  parameter int unsigned NODE_CAPACITY = btmx_pkg::NODE_CAPACITY_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire btmx_pkg::req_word_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output btmx_pkg::res_word_t      out_data_o
);

  import btmx_pkg::*;

  localparam int unsigned PTR_W = $clog2(NODE_CAPACITY);

  logic               out_valid_q, out_valid_d;
  res_word_t          out_data_q, out_data_d;
  logic               out_free;
  logic               res_valid;
  res_word_t          res_data;
  logic               rd_en, wr_en;
  logic [PTR_W-1:0]   rd_addr, wr_addr;
  logic [2*PTR_W-1:0] rd_data, wr_data;

  btmx_ctrl #(
    .KEY_BITS      (KEY_BITS),
    .NODE_CAPACITY (NODE_CAPACITY),
    .PTR_W         (PTR_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_data_o    (res_data),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_rd_data_i (rd_data),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data)
  );

  btmx_node_mem #(
    .DEPTH  (NODE_CAPACITY),
    .ADDR_W (PTR_W),
    .DATA_W (2 * PTR_W)
  ) u_node_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Output register: free when empty or being drained this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
